// ===== rtl/core/nearest_reference_color_vote_defines.svh =====
// Assertion macros for the colour vote block.
// Taken in by the top level only; needs nothing else.
`ifndef NEAREST_REFERENCE_COLOR_VOTE_DEFINES_SVH
`define NEAREST_REFERENCE_COLOR_VOTE_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define NRCV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrcv assertion failed");

// Next-cycle implication, quiet during reset
`define NRCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrcv assertion failed");

`endif

// ===== rtl/core/nrcv_pkg.sv =====
// Types and constants shared by the colour vote block.
// No dependencies.
package nrcv_pkg;

   // Field widths
   localparam int PULSE_W    = 16;
   localparam int REF_W      = 27;
   localparam int REF_CH_W   = 9;
   localparam int LIMIT_W    = 10;
   localparam int CHAN_W     = 10;
   localparam int SQ_W       = 20;
   localparam int DIST_W     = 21;
   localparam int LIMIT_SQ_W = 20;
   localparam int CLASS_W    = 2;
   localparam int CSR_IDX_W  = 2;

   // Class codes
   localparam logic [CLASS_W-1:0] CLASS_RED     = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_BLUE    = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_YELLOW  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_RED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_BLUE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_YELLOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LIMIT = 2'd3;

   // Register reset values
   localparam logic [REF_W-1:0]      REF_RED_RESET     = 27'd39398450;
   localparam logic [REF_W-1:0]      REF_BLUE_RESET    = 27'd13184150;
   localparam logic [REF_W-1:0]      REF_YELLOW_RESET  = 27'd39352380;
   localparam logic [LIMIT_W-1:0]    MATCH_LIMIT_RESET = 10'd50;
   localparam logic [LIMIT_SQ_W-1:0] LIMIT_SQ_RESET    = 20'd2500;

   // Timeout reading and divide by 100 as (x >> 2) / 25, the latter by reciprocal
   localparam logic [CHAN_W-1:0] TIMEOUT_VALUE = 10'd255;
   localparam int                RECIP_W       = 15;
   localparam int                PROD_W        = 29;
   localparam int                RECIP_SHIFT   = 19;
   localparam logic [RECIP_W-1:0] DIV25_RECIP  = 15'd20972;

   typedef struct packed {
      logic [PULSE_W-1:0] red_pulse_us;
      logic [PULSE_W-1:0] green_pulse_us;
      logic [PULSE_W-1:0] blue_pulse_us;
   } req_type;

   typedef struct packed {
      logic [CLASS_W-1:0] sample_class;
      logic               vote_done;
      logic [CLASS_W-1:0] voted_class;
   } rsp_type;

   // Live configuration seen by the classifier
   typedef struct packed {
      logic [REF_W-1:0]      ref_red;
      logic [REF_W-1:0]      ref_blue;
      logic [REF_W-1:0]      ref_yellow;
      logic [LIMIT_SQ_W-1:0] limit_sq;
   } cfg_type;

   // One classified reading moving through the queue
   typedef struct packed {
      logic               valid;
      logic [CLASS_W-1:0] sample_class;
   } item_type;

   // Queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/core/nrcv_queue.sv =====
// Short queue of classified readings between classifier and voter.
// Depends on nrcv_pkg.
module nrcv_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  nrcv_pkg::item_type  push,
   input  logic                pop_ready,
   output nrcv_pkg::item_type  head,
   output nrcv_pkg::qstat_type status
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [nrcv_pkg::CLASS_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push.valid && !status.full;
   assign do_pop       = !status.empty && pop_ready;

   assign head.valid        = !status.empty;
   assign head.sample_class = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.sample_class;
      end
   end

endmodule

// ===== rtl/core/nrcv_front.sv =====
// Front end: takes readings, scales channels, measures distance to the
// three references and classifies. Depends on nrcv_pkg.
module nrcv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  nrcv_pkg::req_type   req_data,
   input  nrcv_pkg::cfg_type   cfg,
   input  nrcv_pkg::qstat_type q_status,
   output nrcv_pkg::item_type  push
);
   localparam int NCH  = 3;
   localparam int NREF = 3;

   logic                          advance;

   // Stage 1: channel values
   logic                          s1_valid_ff;
   logic [nrcv_pkg::CHAN_W-1:0]   chan_ff [NCH];
   logic [nrcv_pkg::CHAN_W-1:0]   chan_in [NCH];
   logic [nrcv_pkg::PULSE_W-1:0]  pulse   [NCH];
   logic [nrcv_pkg::PROD_W-1:0]   prod    [NCH];

   // Stage 2: squared differences
   logic                          s2_valid_ff;
   logic [nrcv_pkg::SQ_W-1:0]     sq_ff [NREF][NCH];
   logic [nrcv_pkg::SQ_W-1:0]     sq_in [NREF][NCH];
   logic [nrcv_pkg::REF_W-1:0]    refs  [NREF];

   // Stage 3: distances
   logic                          s3_valid_ff;
   logic [nrcv_pkg::DIST_W-1:0]   dist_ff [NREF];
   logic [nrcv_pkg::DIST_W-1:0]   dist_in [NREF];

   logic [nrcv_pkg::DIST_W-1:0]   best;
   logic [nrcv_pkg::CLASS_W-1:0]  cls;

   // Whole pipe moves unless the last stage is blocked by a full queue
   assign advance   = !s3_valid_ff || !q_status.full;
   assign req_stall = !advance;

   assign pulse[0] = req_data.red_pulse_us;
   assign pulse[1] = req_data.green_pulse_us;
   assign pulse[2] = req_data.blue_pulse_us;

   assign refs[0] = cfg.ref_red;
   assign refs[1] = cfg.ref_blue;
   assign refs[2] = cfg.ref_yellow;

   // Timeout maps to 255, otherwise floor(pulse / 100)
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         prod[k] = nrcv_pkg::PROD_W'(pulse[k][nrcv_pkg::PULSE_W-1:2])
                 * nrcv_pkg::PROD_W'(nrcv_pkg::DIV25_RECIP);
         if (pulse[k] == '0) begin
            chan_in[k] = nrcv_pkg::TIMEOUT_VALUE;
         end else begin
            chan_in[k] = prod[k][nrcv_pkg::RECIP_SHIFT +: nrcv_pkg::CHAN_W];
         end
      end
   end

   // Absolute difference against each reference channel, squared
   always_comb begin
      logic [nrcv_pkg::CHAN_W-1:0] refc;
      logic [nrcv_pkg::CHAN_W-1:0] diff;
      refc = '0;
      diff = '0;
      for (int c = 0; c < NREF; c++) begin
         for (int k = 0; k < NCH; k++) begin
            refc = nrcv_pkg::CHAN_W'(refs[c][nrcv_pkg::REF_CH_W*k +: nrcv_pkg::REF_CH_W]);
            diff = (chan_ff[k] >= refc) ? chan_ff[k] - refc : refc - chan_ff[k];
            sq_in[c][k] = nrcv_pkg::SQ_W'(diff) * nrcv_pkg::SQ_W'(diff);
         end
      end
   end

   // Sum of squares per reference
   always_comb begin
      for (int c = 0; c < NREF; c++) begin
         dist_in[c] = nrcv_pkg::DIST_W'(sq_ff[c][0]) + nrcv_pkg::DIST_W'(sq_ff[c][1])
                    + nrcv_pkg::DIST_W'(sq_ff[c][2]);
      end
   end

   // Nearest reference, earlier one wins ties; reject beyond the limit
   always_comb begin
      best = dist_ff[0];
      cls  = nrcv_pkg::CLASS_RED;
      if (dist_ff[1] < best) begin
         best = dist_ff[1];
         cls  = nrcv_pkg::CLASS_BLUE;
      end
      if (dist_ff[2] < best) begin
         best = dist_ff[2];
         cls  = nrcv_pkg::CLASS_YELLOW;
      end
      if (best > nrcv_pkg::DIST_W'(cfg.limit_sq)) begin
         cls = nrcv_pkg::CLASS_UNKNOWN;
      end
   end

   assign push.valid        = s3_valid_ff && !q_status.full;
   assign push.sample_class = cls;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         chan_ff <= chan_in;
         sq_ff   <= sq_in;
         dist_ff <= dist_in;
      end
   end

endmodule

// ===== rtl/core/nrcv_back.sv =====
// Back end: counts votes over each window and drives the response register.
// Depends on nrcv_pkg.
module nrcv_back #(
   parameter int VOTE_SAMPLES = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  nrcv_pkg::item_type head,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nrcv_pkg::rsp_type  rsp_data
);
   localparam int CNT_W = $clog2(VOTE_SAMPLES + 1);

   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  red_ff, red_in;
   logic [CNT_W-1:0]  blue_ff, blue_in;
   logic [CNT_W-1:0]  yellow_ff, yellow_in;
   logic [CNT_W-1:0]  top;
   logic              rsp_valid_ff;
   nrcv_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              take;
   logic              window_end;

   // Output register frees when empty or when its transaction completes
   assign pop_ready  = !rsp_valid_ff || !rsp_stall;
   assign take       = head.valid && pop_ready;
   assign window_end = (pos_ff == CNT_W'(VOTE_SAMPLES - 1));

   // Tally this reading, then pick the plurality if the window closes
   always_comb begin
      red_in    = red_ff    + CNT_W'(head.sample_class == nrcv_pkg::CLASS_RED);
      blue_in   = blue_ff   + CNT_W'(head.sample_class == nrcv_pkg::CLASS_BLUE);
      yellow_in = yellow_ff + CNT_W'(head.sample_class == nrcv_pkg::CLASS_YELLOW);
      pos_in    = pos_ff + 1'b1;

      rsp_data_in.sample_class = head.sample_class;
      rsp_data_in.vote_done    = window_end;
      rsp_data_in.voted_class  = nrcv_pkg::CLASS_RED;
      top = '0;

      if (window_end) begin
         rsp_data_in.voted_class = nrcv_pkg::CLASS_UNKNOWN;
         if (red_in > top) begin
            top = red_in;
            rsp_data_in.voted_class = nrcv_pkg::CLASS_RED;
         end
         if (blue_in > top) begin
            top = blue_in;
            rsp_data_in.voted_class = nrcv_pkg::CLASS_BLUE;
         end
         if (yellow_in > top) begin
            rsp_data_in.voted_class = nrcv_pkg::CLASS_YELLOW;
         end
         red_in    = '0;
         blue_in   = '0;
         yellow_in = '0;
         pos_in    = '0;
      end
   end

   // Window counters
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         red_ff    <= '0;
         blue_ff   <= '0;
         yellow_ff <= '0;
      end else if (take) begin
         pos_ff    <= pos_in;
         red_ff    <= red_in;
         blue_ff   <= blue_in;
         yellow_ff <= yellow_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/nearest_reference_color_vote.sv =====
// Colour reading classifier with windowed plurality vote.
// Each reading passes the classifier stages, the queue and the response register.
// Throughput: one reading per cycle; the three-stage classifier only halts
// when the QUEUE_DEPTH classified-reading queue is full.
// Reset (synchronous): references and limit take their defaults, vote
// counters and window position clear, no response is pending.
module nearest_reference_color_vote #(
   parameter int VOTE_SAMPLES = 5,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // Readings
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nrcv_pkg::req_type                   req_data,
   // Responses
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nrcv_pkg::rsp_type                   rsp_data,
   // Register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nrcv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nrcv_pkg::REF_W-1:0]          csr_wdata
);
`include "nearest_reference_color_vote_defines.svh"

   logic [nrcv_pkg::REF_W-1:0]      ref_red_ff;
   logic [nrcv_pkg::REF_W-1:0]      ref_blue_ff;
   logic [nrcv_pkg::REF_W-1:0]      ref_yellow_ff;
   logic [nrcv_pkg::LIMIT_W-1:0]    match_limit_ff;
   logic [nrcv_pkg::LIMIT_SQ_W-1:0] limit_sq_ff, limit_sq_in;
   logic                            csr_write;

   nrcv_pkg::cfg_type   cfg;
   nrcv_pkg::item_type  push;
   nrcv_pkg::item_type  head;
   nrcv_pkg::qstat_type q_status;
   logic                pop_ready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_red_ff     <= nrcv_pkg::REF_RED_RESET;
         ref_blue_ff    <= nrcv_pkg::REF_BLUE_RESET;
         ref_yellow_ff  <= nrcv_pkg::REF_YELLOW_RESET;
         match_limit_ff <= nrcv_pkg::MATCH_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            nrcv_pkg::CSR_REF_RED: begin
               ref_red_ff <= csr_wdata;
            end
            nrcv_pkg::CSR_REF_BLUE: begin
               ref_blue_ff <= csr_wdata;
            end
            nrcv_pkg::CSR_REF_YELLOW: begin
               ref_yellow_ff <= csr_wdata;
            end
            nrcv_pkg::CSR_MATCH_LIMIT: begin
               match_limit_ff <= csr_wdata[nrcv_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Squared match limit, refreshed every cycle
   assign limit_sq_in = nrcv_pkg::LIMIT_SQ_W'(match_limit_ff)
                      * nrcv_pkg::LIMIT_SQ_W'(match_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_sq_ff <= nrcv_pkg::LIMIT_SQ_RESET;
      end else begin
         limit_sq_ff <= limit_sq_in;
      end
   end

   assign cfg.ref_red    = ref_red_ff;
   assign cfg.ref_blue   = ref_blue_ff;
   assign cfg.ref_yellow = ref_yellow_ff;
   assign cfg.limit_sq   = limit_sq_ff;

   nrcv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_status  (q_status),
      .push      (push)
   );

   nrcv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (pop_ready),
      .head      (head),
      .status    (q_status)
   );

   nrcv_back #(
      .VOTE_SAMPLES (VOTE_SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Front never pushes into a full queue
   `NRCV_ASSERT_NOW(a_no_overflow, clock, reset, push.valid, !q_status.full)
   // An empty queue never holds back readings
   `NRCV_ASSERT_NOW(a_empty_no_stall, clock, reset, q_status.empty, !req_stall)
   // Voted class only carries a value at a window end
   `NRCV_ASSERT_NOW(a_vote_quiet, clock, reset, rsp_valid && !rsp_data.vote_done,
      rsp_data.voted_class == nrcv_pkg::CLASS_RED)
   // A response taken with the queue empty leaves nothing pending
   `NRCV_ASSERT_NEXT(a_drain, clock, reset,
      rsp_valid && !rsp_stall && !head.valid, !rsp_valid)

endmodule

// ===== dv/tb_nearest_reference_color_vote.sv =====
// Self-checking testbench for the colour reading classifier and window vote.
// Needs nrcv_pkg and nearest_reference_color_vote; it predicts every response
// itself and compares it field by field under random idling and back-pressure.
module tb_nearest_reference_color_vote;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_LEN    = 5;
   localparam int TIMEOUT_LEVEL = 255;
   localparam int PULSE_STEP    = 100;
   localparam int MAX_LEVEL     = 655;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_PRINTED   = 100;

   // DUT connections, inputs driven from time zero
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   nrcv_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   nrcv_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [nrcv_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [nrcv_pkg::REF_W-1:0]     csr_wdata = '0;

   // Shadow configuration and vote state of the predictor
   logic [nrcv_pkg::REF_W-1:0]   ref_red_cfg    = nrcv_pkg::REF_RED_RESET;
   logic [nrcv_pkg::REF_W-1:0]   ref_blue_cfg   = nrcv_pkg::REF_BLUE_RESET;
   logic [nrcv_pkg::REF_W-1:0]   ref_yellow_cfg = nrcv_pkg::REF_YELLOW_RESET;
   logic [nrcv_pkg::LIMIT_W-1:0] limit_cfg      = nrcv_pkg::MATCH_LIMIT_RESET;
   int unsigned                  window_pos     = 0;
   int unsigned                  red_votes      = 0;
   int unsigned                  blue_votes     = 0;
   int unsigned                  yellow_votes   = 0;

   nrcv_pkg::rsp_type expected_class_q[$];

   // Run control and bookkeeping
   bit idle_on        = 1'b1;
   int hold_len       = 0;
   int hold_seq       = 0;
   int hold_seq_seen  = 0;
   int hold_left      = 0;
   int rx_wait        = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int readings_sent  = 0;
   int rsp_count      = 0;
   int windows_closed = 0;
   int unknown_seen   = 0;

   nearest_reference_color_vote uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("nearest_reference_color_vote: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Pulse width to channel level: timeout reads as level 255
   function automatic int unsigned pulse_level(input logic [nrcv_pkg::PULSE_W-1:0] pulse);
      return (pulse == '0) ? TIMEOUT_LEVEL : int'(pulse) / PULSE_STEP;
   endfunction

   function automatic int unsigned sq_gap(input int unsigned a, input int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   // Squared distance to one packed reference colour
   function automatic int unsigned colour_distance(input int unsigned r, input int unsigned g,
                                                   input int unsigned b,
                                                   input logic [nrcv_pkg::REF_W-1:0] centre);
      return sq_gap(r, centre[8:0]) + sq_gap(g, centre[17:9]) + sq_gap(b, centre[26:18]);
   endfunction

   // Classify one reading and advance the vote window
   function automatic nrcv_pkg::rsp_type predict_reading(input nrcv_pkg::req_type rd);
      int unsigned                  r, g, b, best, d, lim_sq, top;
      logic [nrcv_pkg::CLASS_W-1:0] cls;
      nrcv_pkg::rsp_type            res;
      res  = '0;
      r    = pulse_level(rd.red_pulse_us);
      g    = pulse_level(rd.green_pulse_us);
      b    = pulse_level(rd.blue_pulse_us);
      best = colour_distance(r, g, b, ref_red_cfg);
      cls  = nrcv_pkg::CLASS_RED;
      d    = colour_distance(r, g, b, ref_blue_cfg);
      if (d < best) begin
         best = d;
         cls  = nrcv_pkg::CLASS_BLUE;
      end
      d = colour_distance(r, g, b, ref_yellow_cfg);
      if (d < best) begin
         best = d;
         cls  = nrcv_pkg::CLASS_YELLOW;
      end
      lim_sq = int'(limit_cfg) * int'(limit_cfg);
      if (best > lim_sq) cls = nrcv_pkg::CLASS_UNKNOWN;

      case (cls)
         nrcv_pkg::CLASS_RED:    red_votes++;
         nrcv_pkg::CLASS_BLUE:   blue_votes++;
         nrcv_pkg::CLASS_YELLOW: yellow_votes++;
         default:                ;
      endcase
      res.sample_class = cls;

      // Window complete: plurality with ties to the earlier colour
      window_pos++;
      if (window_pos >= WINDOW_LEN) begin
         top             = 0;
         res.voted_class = nrcv_pkg::CLASS_UNKNOWN;
         if (red_votes > top) begin
            top             = red_votes;
            res.voted_class = nrcv_pkg::CLASS_RED;
         end
         if (blue_votes > top) begin
            top             = blue_votes;
            res.voted_class = nrcv_pkg::CLASS_BLUE;
         end
         if (yellow_votes > top) begin
            top             = yellow_votes;
            res.voted_class = nrcv_pkg::CLASS_YELLOW;
         end
         res.vote_done = 1'b1;
         window_pos    = 0;
         red_votes     = 0;
         blue_votes    = 0;
         yellow_votes  = 0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: checking and stall generation
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR t=%0t response %0d: %s got %0d, expected %0d",
                  $time, rsp_count, what, got, want);
   endtask

   task automatic check_response(input nrcv_pkg::rsp_type got);
      nrcv_pkg::rsp_type want;
      rsp_count++;
      if (got.vote_done) windows_closed++;
      if (got.sample_class == nrcv_pkg::CLASS_UNKNOWN) unknown_seen++;
      if (expected_class_q.size() == 0) begin
         report_mismatch("response with nothing outstanding", int'(got), 0);
      end else begin
         want = expected_class_q.pop_front();
         if (got.sample_class !== want.sample_class)
            report_mismatch("sample_class", got.sample_class, want.sample_class);
         if (got.vote_done !== want.vote_done)
            report_mismatch("vote_done", got.vote_done, want.vote_done);
         if (got.voted_class !== want.voted_class)
            report_mismatch("voted_class", got.voted_class, want.voted_class);
      end
   endtask

   // Values read here are the ones present just before the edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_response(rsp_data);
            rx_wait = idle_on ? int'($urandom_range(0, 3)) : 0;
         end
         // long hold-off requested by a test
         if (hold_seq_seen != hold_seq) begin
            hold_seq_seen = hold_seq;
            hold_left     = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one reading; returns at the edge that accepts it, valid left high
   task automatic send_reading(input nrcv_pkg::req_type rd);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 3)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rd;
      do @(posedge clock); while (req_stall);
      expected_class_q.push_back(predict_reading(rd));
      readings_sent++;
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_class_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [nrcv_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [nrcv_pkg::REF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         nrcv_pkg::CSR_REF_RED:     ref_red_cfg    = val;
         nrcv_pkg::CSR_REF_BLUE:    ref_blue_cfg   = val;
         nrcv_pkg::CSR_REF_YELLOW:  ref_yellow_cfg = val;
         nrcv_pkg::CSR_MATCH_LIMIT: limit_cfg      = val[nrcv_pkg::LIMIT_W-1:0];
         default:                   ;
      endcase
   endtask

   // Reprogram all four registers once the block has gone quiet
   task automatic program_colours(input logic [nrcv_pkg::REF_W-1:0] red_c,
                                  input logic [nrcv_pkg::REF_W-1:0] blue_c,
                                  input logic [nrcv_pkg::REF_W-1:0] yellow_c,
                                  input logic [nrcv_pkg::REF_W-1:0] limit_w);
      drain_responses();
      write_register(nrcv_pkg::CSR_REF_RED, red_c);
      write_register(nrcv_pkg::CSR_REF_BLUE, blue_c);
      write_register(nrcv_pkg::CSR_REF_YELLOW, yellow_c);
      write_register(nrcv_pkg::CSR_MATCH_LIMIT, limit_w);
      csr_valid <= 1'b0;
   endtask

   task automatic program_random();
      program_colours(nrcv_pkg::REF_W'($urandom()), nrcv_pkg::REF_W'($urandom()),
                      nrcv_pkg::REF_W'($urandom()), nrcv_pkg::REF_W'($urandom()));
   endtask

   function automatic nrcv_pkg::req_type mk_reading(input int r, input int g, input int b);
      nrcv_pkg::req_type rd;
      rd.red_pulse_us   = nrcv_pkg::PULSE_W'(r);
      rd.green_pulse_us = nrcv_pkg::PULSE_W'(g);
      rd.blue_pulse_us  = nrcv_pkg::PULSE_W'(b);
      return rd;
   endfunction

   // Any pulse width that lands on the given level, now and then a timeout
   function automatic logic [nrcv_pkg::PULSE_W-1:0] level_to_pulse(input int lvl);
      if ($urandom_range(0, 24) == 0) return '0;
      if (lvl <= 0) return nrcv_pkg::PULSE_W'($urandom_range(1, 99));
      if (lvl >= MAX_LEVEL)
         return nrcv_pkg::PULSE_W'(MAX_LEVEL * PULSE_STEP + $urandom_range(0, 35));
      return nrcv_pkg::PULSE_W'(lvl * PULSE_STEP + int'($urandom_range(0, 99)));
   endfunction

   // Mostly readings scattered around a reference colour, some raw noise
   function automatic nrcv_pkg::req_type random_reading();
      nrcv_pkg::req_type          rd;
      logic [nrcv_pkg::REF_W-1:0] centre;
      int                         spread, ch;
      int                         lv[3];
      if ($urandom_range(0, 99) < 12) begin
         rd.red_pulse_us   = nrcv_pkg::PULSE_W'($urandom());
         rd.green_pulse_us = nrcv_pkg::PULSE_W'($urandom());
         rd.blue_pulse_us  = nrcv_pkg::PULSE_W'($urandom());
         return rd;
      end
      case ($urandom_range(0, 2))
         0:       centre = ref_red_cfg;
         1:       centre = ref_blue_cfg;
         default: centre = ref_yellow_cfg;
      endcase
      spread = (limit_cfg < 4) ? 4 : int'(limit_cfg);
      for (ch = 0; ch < 3; ch++) begin
         lv[ch] = int'(centre[ch*nrcv_pkg::REF_CH_W +: nrcv_pkg::REF_CH_W])
                  + int'($urandom_range(0, 2 * spread)) - spread;
         if (lv[ch] < 0) lv[ch] = 0;
         if (lv[ch] > MAX_LEVEL) lv[ch] = MAX_LEVEL;
      end
      rd.red_pulse_us   = level_to_pulse(lv[0]);
      rd.green_pulse_us = level_to_pulse(lv[1]);
      rd.blue_pulse_us  = level_to_pulse(lv[2]);
      return rd;
   endfunction

   task automatic run_readings(input int count);
      repeat (count) send_reading(random_reading());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Default references: exact hits, timeouts, extremes, exact fit, vote ties
   task automatic test_directed_defaults();
      // one vote each: tie goes to red
      send_reading(mk_reading(5000, 15000, 15000));
      send_reading(mk_reading(15000, 15000, 5000));
      send_reading(mk_reading(6000, 6000, 15000));
      send_reading(mk_reading(0, 0, 0));
      send_reading(mk_reading(65535, 65535, 65535));
      // blue and yellow tie, one reading just past the limit
      send_reading(mk_reading(15099, 15050, 5099));
      send_reading(mk_reading(6099, 6000, 15000));
      send_reading(mk_reading(15000, 15000, 5000));
      send_reading(mk_reading(6000, 6099, 15099));
      send_reading(mk_reading(10100, 15000, 15000));
      // nothing matches: empty window
      send_reading(mk_reading(1, 1, 1));
      send_reading(mk_reading(99, 99, 99));
      send_reading(mk_reading(100, 100, 100));
      send_reading(mk_reading(65535, 0, 32768));
      send_reading(mk_reading(0, 15000, 15000));
      // distance exactly at the limit still counts; red and blue tie
      send_reading(mk_reading(10000, 15000, 15000));
      send_reading(mk_reading(5050, 15000, 15000));
      send_reading(mk_reading(15000, 15000, 5000));
      send_reading(mk_reading(15000, 15000, 5000));
      send_reading(mk_reading(6000, 6000, 15000));
   endtask

   // All references equal: every distance ties, so red always wins
   task automatic test_reference_ties();
      program_colours(nrcv_pkg::REF_RED_RESET, nrcv_pkg::REF_RED_RESET,
                      nrcv_pkg::REF_RED_RESET, 27'h5A5A7FF);
      send_reading(mk_reading(5000, 15000, 15000));
      send_reading(mk_reading(0, 0, 0));
      send_reading(mk_reading(65535, 65535, 65535));
      send_reading(mk_reading(10000, 10000, 10000));
      send_reading(mk_reading(2500, 40000, 50000));
   endtask

   task automatic test_random_defaults();
      program_colours(nrcv_pkg::REF_RED_RESET, nrcv_pkg::REF_BLUE_RESET,
                      nrcv_pkg::REF_YELLOW_RESET,
                      nrcv_pkg::REF_W'(nrcv_pkg::MATCH_LIMIT_RESET));
      run_readings(280);
   endtask

   task automatic test_random_references();
      program_random();
      run_readings(280);
   endtask

   // Extremes: zero references with only exact matches, then full-scale ones
   task automatic test_config_extremes();
      program_colours('0, '0, '0, 27'h400);
      run_readings(220);
      program_colours('1, '1, '1, '1);
      run_readings(220);
   endtask

   task automatic test_back_to_back();
      program_random();
      idle_on = 1'b0;
      run_readings(350);
      idle_on = 1'b1;
   endtask

   // Receiver holds off while readings keep coming, then the sender waits
   // for the pipeline to empty before carrying on
   task automatic test_backpressure();
      program_random();
      idle_on  = 1'b0;
      hold_len = 80;
      hold_seq++;
      run_readings(60);
      idle_on = 1'b1;
      drain_responses();
      run_readings(240);
   endtask

   task automatic test_random_mix();
      repeat (4) begin
         program_random();
         run_readings(75);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_reference_ties();
      test_random_defaults();
      test_random_references();
      test_config_extremes();
      test_back_to_back();
      test_backpressure();
      test_random_mix();

      drain_responses();
      repeat (10) @(posedge clock);

      $display("Run covered %0d readings in %0d vote windows, %0d of them unknown,",
               readings_sent, windows_closed, unknown_seen);
      $display("over default, tied, extreme and random references in %0d cycles.",
               cycle_count);
      if (error_count == 0)
         $display("nearest_reference_color_vote: match");
      else
         $display("nearest_reference_color_vote: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nrcv_pkg.sv
rtl/core/nrcv_queue.sv
rtl/core/nrcv_front.sv
rtl/core/nrcv_back.sv
rtl/core/nearest_reference_color_vote.sv
dv/tb_nearest_reference_color_vote.sv
